[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the embedded-controller host master.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define EHTM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define EHTM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ehtm_pkg.sv]
// ---------------------------------------------------------------------------
// ehtm_pkg
// Types and constants shared by the embedded-controller host master modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ehtm_pkg;

    // Transfer phase of the host handshake.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_READY,
        PH_CMD,
        PH_ADDR,
        PH_OBF
    } phase_t;

    // Port action taken on one poll tick.
    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_CMD_WR   = 2'd1,
        ACT_DATA_WR  = 2'd2,
        ACT_DATA_RD  = 2'd3
    } action_t;

    // Configuration register indices.
    localparam logic [1:0] CFG_POLL_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_ATTEMPT_LIMIT = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN    = 2'd2;

    localparam logic [15:0] POLL_LIMIT_RST    = 16'd1000;
    localparam logic [7:0]  ATTEMPT_LIMIT_RST = 8'd3;
    localparam logic        BIG_ENDIAN_RST    = 1'b1;

    // Embedded-controller command codes and status bits.
    localparam logic [7:0] EC_CMD_READ  = 8'h80;
    localparam logic [7:0] EC_CMD_WRITE = 8'h81;
    localparam int unsigned ST_OBF_BIT  = 0;
    localparam int unsigned ST_IBF_BIT  = 1;

    typedef struct packed {
        logic [15:0] poll_limit;
        logic [7:0]  attempt_limit;
        logic        big_endian_words;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic        req_write;
        logic        req_word;
        logic [7:0]  req_reg;
        logic [15:0] req_value;
        logic [7:0]  ec_status;
        logic [7:0]  ec_data;
    } item_t;

    typedef struct packed {
        action_t     bus_action;
        logic [7:0]  bus_byte;
        logic        done_res;
        logic        success;
        logic [15:0] read_value;
        logic        busy_res;
        logic        request_dropped;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/ehtm_cfg.sv]
// ---------------------------------------------------------------------------
// ehtm_cfg
// Configuration registers: poll limit, attempt limit and word byte order.
// ---------------------------------------------------------------------------
`default_nettype none

module ehtm_cfg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [15:0]      cfg_data,
    output ehtm_pkg::cfg_t        cfg
);

    ehtm_pkg::cfg_t cfg_reg;
    ehtm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ehtm_pkg::CFG_POLL_LIMIT:    cfg_next.poll_limit       = cfg_data;
                ehtm_pkg::CFG_ATTEMPT_LIMIT: cfg_next.attempt_limit    = cfg_data[7:0];
                ehtm_pkg::CFG_BIG_ENDIAN:    cfg_next.big_endian_words = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_limit       <= ehtm_pkg::POLL_LIMIT_RST;
            cfg_reg.attempt_limit    <= ehtm_pkg::ATTEMPT_LIMIT_RST;
            cfg_reg.big_endian_words <= ehtm_pkg::BIG_ENDIAN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hw/rtl/ehtm_in_stage.sv]
// ---------------------------------------------------------------------------
// ehtm_in_stage
// Input register holding one poll tick until the step logic takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module ehtm_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire ehtm_pkg::item_t in_item,
    input  wire logic            take,
    output logic                 item_valid,
    output ehtm_pkg::item_t      item
);

    logic            valid_reg;
    logic            valid_next;
    ehtm_pkg::item_t item_reg;

    // The register refills whenever its content moves on in the same cycle.
    assign in_stall   = valid_reg && !take;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[hw/rtl/ehtm_core.sv]
// ---------------------------------------------------------------------------
// ehtm_core
// Transaction state and the per-tick step logic of the host handshake.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ehtm_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire ehtm_pkg::item_t item,
    input  wire ehtm_pkg::cfg_t  cfg,
    output ehtm_pkg::result_t    res
);

    ehtm_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      poll_count_reg, poll_count_next;
    logic [7:0]       attempt_count_reg, attempt_count_next;
    logic             op_write_reg, op_write_next;
    logic             op_word_reg, op_word_next;
    logic [7:0]       op_reg_reg, op_reg_next;
    logic [15:0]      op_value_reg, op_value_next;
    logic             second_byte_reg, second_byte_next;
    logic [7:0]       first_read_byte_reg, first_read_byte_next;

    // Values after a new request has been taken on this tick.
    logic             start;
    ehtm_pkg::phase_t ph0;
    logic             wr0, word0, sb0;
    logic [7:0]       reg0, frb0;
    logic [15:0]      val0, pc0;
    logic [7:0]       ac0;

    logic             active, zero_lim, run, met, hit;
    logic [15:0]      pc_inc;
    logic [7:0]       ac_inc;
    logic             poll_fail, miss_fail, give_up;
    logic             xfer_end, half_end, fin_fail, fin_ok, finish;
    logic [7:0]       xfer_data, wr_byte;
    logic [15:0]      word_value;

    assign start = item.kind && (phase_reg == ehtm_pkg::PH_IDLE);
    assign ph0   = start ? ehtm_pkg::PH_READY : phase_reg;
    assign wr0   = start ? item.req_write : op_write_reg;
    assign word0 = start ? item.req_word  : op_word_reg;
    assign reg0  = start ? item.req_reg   : op_reg_reg;
    assign val0  = start ? item.req_value : op_value_reg;
    assign sb0   = start ? 1'b0  : second_byte_reg;
    assign frb0  = start ? 8'h00 : first_read_byte_reg;
    assign pc0   = start ? 16'h0 : poll_count_reg;
    assign ac0   = start ? 8'h00 : attempt_count_reg;

    assign active   = (ph0 != ehtm_pkg::PH_IDLE);
    assign zero_lim = (cfg.attempt_limit == 8'h00) || (cfg.poll_limit == 16'h0);
    assign run      = active && !zero_lim;
    assign met      = (ph0 == ehtm_pkg::PH_OBF) ? item.ec_status[ehtm_pkg::ST_OBF_BIT]
                                                : !item.ec_status[ehtm_pkg::ST_IBF_BIT];
    assign hit      = run && met;

    assign pc_inc    = pc0 + 16'd1;
    assign ac_inc    = ac0 + 8'd1;
    assign poll_fail = (pc_inc >= cfg.poll_limit) || (pc_inc == 16'h0);
    assign miss_fail = run && !met && poll_fail;
    assign give_up   = miss_fail && ((ac_inc >= cfg.attempt_limit) || (ac_inc == 8'h00));

    // A byte transfer ends with the data write or with the data read.
    assign xfer_end = hit && (((ph0 == ehtm_pkg::PH_ADDR) && wr0)
                              || (ph0 == ehtm_pkg::PH_OBF));
    assign half_end = xfer_end && word0 && !sb0;
    assign fin_fail = (active && zero_lim) || give_up;
    assign fin_ok   = xfer_end && !half_end;
    assign finish   = fin_fail || fin_ok;

    assign xfer_data = (ph0 == ehtm_pkg::PH_OBF) ? item.ec_data : 8'h00;

    always_comb
    begin
        if (!word0)
            wr_byte = val0[7:0];
        else if (cfg.big_endian_words)
            wr_byte = sb0 ? val0[7:0] : val0[15:8];
        else
            wr_byte = sb0 ? val0[15:8] : val0[7:0];
    end

    always_comb
    begin
        if (wr0)
            word_value = 16'h0;
        else if (!word0)
            word_value = {8'h00, xfer_data};
        else if (cfg.big_endian_words)
            word_value = {frb0, xfer_data};
        else
            word_value = {xfer_data, frb0};
    end

    // Next state.
    always_comb
    begin
        phase_next           = ph0;
        poll_count_next      = pc0;
        attempt_count_next   = ac0;
        op_write_next        = wr0;
        op_word_next         = word0;
        op_reg_next          = reg0;
        op_value_next        = val0;
        second_byte_next     = sb0;
        first_read_byte_next = frb0;
        if (finish)
        begin
            phase_next         = ehtm_pkg::PH_IDLE;
            poll_count_next    = 16'h0;
            attempt_count_next = 8'h00;
            second_byte_next   = 1'b0;
        end
        else if (half_end)
        begin
            first_read_byte_next = xfer_data;
            second_byte_next     = 1'b1;
            phase_next           = ehtm_pkg::PH_READY;
            poll_count_next      = 16'h0;
            attempt_count_next   = 8'h00;
        end
        else if (hit)
        begin
            poll_count_next = 16'h0;
            unique case (ph0)
                ehtm_pkg::PH_READY: phase_next = ehtm_pkg::PH_CMD;
                ehtm_pkg::PH_CMD:   phase_next = ehtm_pkg::PH_ADDR;
                ehtm_pkg::PH_ADDR:  phase_next = ehtm_pkg::PH_OBF;
                default:            phase_next = ph0;
            endcase
        end
        else if (miss_fail)
        begin
            attempt_count_next = ac_inc;
            poll_count_next    = 16'h0;
            phase_next         = ehtm_pkg::PH_READY;
        end
        else if (run)
        begin
            poll_count_next = pc_inc;
        end
    end

    // Outputs of this tick.
    always_comb
    begin
        res.bus_action = ehtm_pkg::ACT_NONE;
        res.bus_byte   = 8'h00;
        if (hit)
        begin
            unique case (ph0)
                ehtm_pkg::PH_READY:
                begin
                    res.bus_action = ehtm_pkg::ACT_CMD_WR;
                    res.bus_byte   = wr0 ? ehtm_pkg::EC_CMD_WRITE : ehtm_pkg::EC_CMD_READ;
                end
                ehtm_pkg::PH_CMD:
                begin
                    res.bus_action = ehtm_pkg::ACT_DATA_WR;
                    res.bus_byte   = reg0 + {7'd0, sb0};
                end
                ehtm_pkg::PH_ADDR:
                begin
                    if (wr0)
                    begin
                        res.bus_action = ehtm_pkg::ACT_DATA_WR;
                        res.bus_byte   = wr_byte;
                    end
                end
                ehtm_pkg::PH_OBF:
                begin
                    res.bus_action = ehtm_pkg::ACT_DATA_RD;
                end
                default:
                begin
                    res.bus_action = ehtm_pkg::ACT_NONE;
                end
            endcase
        end
        res.done_res        = finish;
        res.success         = fin_ok;
        res.read_value      = fin_ok ? word_value : 16'h0;
        res.busy_res        = (phase_next != ehtm_pkg::PH_IDLE);
        res.request_dropped = item.kind && (phase_reg != ehtm_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= ehtm_pkg::PH_IDLE;
            poll_count_reg      <= 16'h0;
            attempt_count_reg   <= 8'h00;
            op_write_reg        <= 1'b0;
            op_word_reg         <= 1'b0;
            op_reg_reg          <= 8'h00;
            op_value_reg        <= 16'h0;
            second_byte_reg     <= 1'b0;
            first_read_byte_reg <= 8'h00;
        end
        else if (step_en)
        begin
            phase_reg           <= phase_next;
            poll_count_reg      <= poll_count_next;
            attempt_count_reg   <= attempt_count_next;
            op_write_reg        <= op_write_next;
            op_word_reg         <= op_word_next;
            op_reg_reg          <= op_reg_next;
            op_value_reg        <= op_value_next;
            second_byte_reg     <= second_byte_next;
            first_read_byte_reg <= first_read_byte_next;
        end
    end

    `EHTM_ASSERT_NXT(a_done_goes_idle, clk, rst_n, step_en && res.done_res, phase_reg == ehtm_pkg::PH_IDLE, "finished request did not return to idle")
    `EHTM_ASSERT_NXT(a_hold_without_step, clk, rst_n, !step_en, $stable(phase_reg) && $stable(poll_count_reg), "state moved without a tick")
    `EHTM_ASSERT_IMP(a_drop_only_busy, clk, rst_n, step_en && res.request_dropped, phase_reg != ehtm_pkg::PH_IDLE, "request dropped while idle")

endmodule

`default_nettype wire

[hw/rtl/ehtm_out_stage.sv]
// ---------------------------------------------------------------------------
// ehtm_out_stage
// Result register holding one result word until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module ehtm_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ehtm_pkg::result_t res_in,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ehtm_pkg::result_t      res_out
);

    logic              valid_reg;
    logic              valid_next;
    ehtm_pkg::result_t res_reg;

    assign free       = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

[hw/rtl/ec_host_transaction_master_unit.sv]
// ---------------------------------------------------------------------------
// ec_host_transaction_master_unit
// Host-side master for the embedded-controller command/data port handshake.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Word
//  --------+-----------+----------------------+----------------------------------
//  in      | to unit   | in_valid / in_stall  | poll tick, optional new request
//  out     | from unit | out_valid / out_stall| port action and request status
//  cfg     | to unit   | cfg_we               | limits and word byte order
//
// Each accepted word is held in the input register and is stepped through the
// handshake state once the output register is free, its result landing in the
// output register; one word a cycle while the output is not stalled.
// The rate is set by the single state update per tick in the step logic.
// Reset (rst_n low, asynchronous) empties both registers, returns the handshake
// to idle and loads the limits with 1000 polls, 3 attempts and big-endian words.
// A stalled result holds the step logic, and the input then stalls in turn.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ec_host_transaction_master_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic        req_write,
    input  wire logic        req_word,
    input  wire logic [7:0]  req_reg,
    input  wire logic [15:0] req_value,
    input  wire logic [7:0]  ec_status,
    input  wire logic [7:0]  ec_data,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       bus_action,
    output logic [7:0]       bus_byte,
    output logic             done_res,
    output logic             success,
    output logic [15:0]      read_value,
    output logic             busy_res,
    output logic             request_dropped
);

    ehtm_pkg::cfg_t    cfg;
    ehtm_pkg::item_t   in_item;
    ehtm_pkg::item_t   item;
    ehtm_pkg::result_t step_res;
    ehtm_pkg::result_t res;
    logic              item_valid;
    logic              out_free;
    logic              take;

    assign in_item.kind      = kind;
    assign in_item.req_write = req_write;
    assign in_item.req_word  = req_word;
    assign in_item.req_reg   = req_reg;
    assign in_item.req_value = req_value;
    assign in_item.ec_status = ec_status;
    assign in_item.ec_data   = ec_data;

    // The held tick is stepped whenever the output register can take its result.
    assign take = item_valid && out_free;

    ehtm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ehtm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ehtm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (take),
        .item    (item),
        .cfg     (cfg),
        .res     (step_res)
    );

    ehtm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res_in    (step_res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res)
    );

    assign bus_action      = res.bus_action;
    assign bus_byte        = res.bus_byte;
    assign done_res        = res.done_res;
    assign success         = res.success;
    assign read_value      = res.read_value;
    assign busy_res        = res.busy_res;
    assign request_dropped = res.request_dropped;

    `EHTM_ASSERT_NXT(a_held_tick_moves_on, clk, rst_n, item_valid && !out_valid, out_valid, "held tick not passed to the output register")

endmodule

`default_nettype wire

[tb/tb_ec_host_transaction_master_unit.sv]
// ---------------------------------------------------------------------------
// tb_ec_host_transaction_master_unit
// Self-checking bench for the embedded-controller host transaction master.
// A predictor follows the host handshake tick by tick and holds the result
// word that every accepted poll tick should produce. It covers byte and word
// reads and writes, retries, timeouts, dropped requests and byte order, across
// a series of limit settings with random idling and back-pressure on both
// channels.
// ---------------------------------------------------------------------------
module tb_ec_host_transaction_master_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import ehtm_pkg::*;

    // -----------------------------------------------------------------------
    // Predictor and store of owed result words. Every accepted poll tick is
    // stepped through a private copy of the handshake state, and the result
    // word that it must produce is queued until the block delivers it.
    // -----------------------------------------------------------------------
    class ec_port_tracker;
        logic [15:0] poll_lim;
        logic [7:0]  attempt_lim;
        logic        big_endian;
        phase_t      step_phase;
        logic [15:0] poll_run;
        logic [7:0]  tries;
        logic        xfer_write;
        logic        xfer_word;
        logic [7:0]  xfer_addr;
        logic [15:0] xfer_value;
        logic        on_second;
        logic [7:0]  early_byte;
        result_t     cur;
        result_t     due_actions[$];
        int          errors;
        int          checked;
        int          n_ticks;
        int          n_ok;
        int          n_failed;
        int          n_dropped;

        function new();
            poll_lim    = POLL_LIMIT_RST;
            attempt_lim = ATTEMPT_LIMIT_RST;
            big_endian  = BIG_ENDIAN_RST;
            step_phase  = PH_IDLE;
            poll_run    = '0;
            tries       = '0;
            xfer_write  = 1'b0;
            xfer_word   = 1'b0;
            xfer_addr   = '0;
            xfer_value  = '0;
            on_second   = 1'b0;
            early_byte  = '0;
            errors      = 0;
            checked     = 0;
            n_ticks     = 0;
            n_ok        = 0;
            n_failed    = 0;
            n_dropped   = 0;
        endfunction

        function void set_limits(logic [15:0] polls, logic [7:0] attempts, logic be);
            poll_lim    = polls;
            attempt_lim = attempts;
            big_endian  = be;
        endfunction

        function bit in_request();
            return step_phase != PH_IDLE;
        endfunction

        function int pending();
            return due_actions.size();
        endfunction

        function void conclude(logic ok, logic [15:0] value);
            cur.done_res   = 1'b1;
            cur.success    = ok;
            cur.read_value = ok ? value : 16'h0000;
            step_phase     = PH_IDLE;
            poll_run       = '0;
            tries          = '0;
            on_second      = 1'b0;
            if (ok)
                n_ok++;
            else
                n_failed++;
        endfunction

        function void give_up_attempt();
            tries    = tries + 8'd1;
            poll_run = '0;
            if (tries >= attempt_lim || tries == 8'd0)
                conclude(1'b0, 16'h0000);
            else
                step_phase = PH_READY;
        endfunction

        function logic [7:0] outgoing_byte();
            if (!xfer_word)
                return xfer_value[7:0];
            if (big_endian)
                return on_second ? xfer_value[7:0] : xfer_value[15:8];
            return on_second ? xfer_value[15:8] : xfer_value[7:0];
        endfunction

        function void byte_finished(logic [7:0] data);
            if (xfer_word && !on_second)
            begin
                early_byte = data;
                on_second  = 1'b1;
                step_phase = PH_READY;
                poll_run   = '0;
                tries      = '0;
            end
            else if (xfer_write)
                conclude(1'b1, 16'h0000);
            else if (!xfer_word)
                conclude(1'b1, {8'h00, data});
            else if (big_endian)
                conclude(1'b1, {early_byte, data});
            else
                conclude(1'b1, {data, early_byte});
        endfunction

        function void note_tick(item_t it);
            logic met;
            cur = '0;
            n_ticks++;
            if (it.kind)
            begin
                if (step_phase != PH_IDLE)
                begin
                    cur.request_dropped = 1'b1;
                    n_dropped++;
                end
                else
                begin
                    xfer_write = it.req_write;
                    xfer_word  = it.req_word;
                    xfer_addr  = it.req_reg;
                    xfer_value = it.req_value;
                    on_second  = 1'b0;
                    early_byte = '0;
                    poll_run   = '0;
                    tries      = '0;
                    step_phase = PH_READY;
                end
            end
            if (step_phase != PH_IDLE)
            begin
                if (attempt_lim == 8'd0 || poll_lim == 16'd0)
                    conclude(1'b0, 16'h0000);
                else
                begin
                    met = (step_phase == PH_OBF) ? it.ec_status[ST_OBF_BIT]
                                                 : !it.ec_status[ST_IBF_BIT];
                    if (met)
                    begin
                        poll_run = '0;
                        case (step_phase)
                            PH_READY:
                            begin
                                cur.bus_action = ACT_CMD_WR;
                                cur.bus_byte   = xfer_write ? EC_CMD_WRITE : EC_CMD_READ;
                                step_phase     = PH_CMD;
                            end
                            PH_CMD:
                            begin
                                cur.bus_action = ACT_DATA_WR;
                                cur.bus_byte   = xfer_addr + {7'd0, on_second};
                                step_phase     = PH_ADDR;
                            end
                            PH_ADDR:
                            begin
                                if (xfer_write)
                                begin
                                    cur.bus_action = ACT_DATA_WR;
                                    cur.bus_byte   = outgoing_byte();
                                    byte_finished(8'h00);
                                end
                                else
                                    step_phase = PH_OBF;
                            end
                            default:
                            begin
                                cur.bus_action = ACT_DATA_RD;
                                byte_finished(it.ec_data);
                            end
                        endcase
                    end
                    else
                    begin
                        poll_run = poll_run + 16'd1;
                        if (poll_run >= poll_lim || poll_run == 16'd0)
                            give_up_attempt();
                    end
                end
            end
            cur.busy_res = (step_phase != PH_IDLE);
            due_actions.push_back(cur);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_action(result_t got);
            result_t want;
            if (due_actions.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none expected, expected nothing, actual %p",
                         $time, got);
            end
            else
            begin
                want = due_actions.pop_front();
                checked++;
                compare_field("bus_action", 16'(want.bus_action), 16'(got.bus_action));
                compare_field("bus_byte", 16'(want.bus_byte), 16'(got.bus_byte));
                compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
                compare_field("success", 16'(want.success), 16'(got.success));
                compare_field("read_value", want.read_value, got.read_value);
                compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
                compare_field("request_dropped", 16'(want.request_dropped),
                              16'(got.request_dropped));
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals and the block under test.
    // -----------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic        req_write;
    logic        req_word;
    logic [7:0]  req_reg;
    logic [15:0] req_value;
    logic [7:0]  ec_status;
    logic [7:0]  ec_data;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  bus_action;
    logic [7:0]  bus_byte;
    logic        done_res;
    logic        success;
    logic [15:0] read_value;
    logic        busy_res;
    logic        request_dropped;

    // When set, neither side idles; one phase of the run keeps it set so that
    // the block also sees a long stretch of back-to-back words.
    bit          steady_run = 1'b0;
    int          settings_used = 0;

    ec_port_tracker tracker = new();

    ec_host_transaction_master_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .req_write       (req_write),
        .req_word        (req_word),
        .req_reg         (req_reg),
        .req_value       (req_value),
        .ec_status       (ec_status),
        .ec_data         (ec_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .bus_action      (bus_action),
        .bus_byte        (bus_byte),
        .done_res        (done_res),
        .success         (success),
        .read_value      (read_value),
        .busy_res        (busy_res),
        .request_dropped (request_dropped)
    );

    // A 12 ns clock: the bench drives on the falling edge and samples on the
    // rising edge, so nothing hinges on the order of events within a step.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Sender side.
    // -----------------------------------------------------------------------

    // Offers one poll tick, after a random number of idle cycles, and holds it
    // until it is taken. It is entered and left on a falling edge; in_valid is
    // left high, so the caller either offers the next word or lowers it.
    task automatic send_tick(input item_t it);
        while (!steady_run && $urandom_range(99, 0) < 23)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        {kind, req_write, req_word, req_reg, req_value, ec_status, ec_data} <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_tick(it);
        @(negedge clk);
    endtask

    task automatic directed_tick(input logic k, input logic wr, input logic wd,
                                 input logic [7:0] addr, input logic [15:0] value,
                                 input logic [7:0] status, input logic [7:0] data);
        send_tick({k, wr, wd, addr, value, status, data});
    endtask

    // Builds a random poll tick. While no request is in flight, a new request
    // is usually offered so that most of the run is spent inside transfers;
    // while one is in flight, an occasional request checks that it is dropped.
    // The IBF and OBF bits are weighted by the phase; all other bits are free.
    function automatic item_t make_tick(input bit in_flight, input int busy_pct,
                                        input int obf_pct);
        item_t it;
        it.kind      = in_flight ? ($urandom_range(99, 0) < 8)
                                 : ($urandom_range(99, 0) < 60);
        it.req_write = 1'($urandom_range(1, 0));
        it.req_word  = 1'($urandom_range(1, 0));
        it.req_reg   = 8'($urandom);
        it.req_value = 16'($urandom);
        it.ec_status = 8'($urandom);
        it.ec_data   = 8'($urandom);
        it.ec_status[ST_IBF_BIT] = ($urandom_range(99, 0) < busy_pct);
        it.ec_status[ST_OBF_BIT] = ($urandom_range(99, 0) < obf_pct);
        return it;
    endfunction

    task automatic run_phase(input int count, input int busy_pct, input int obf_pct);
        repeat (count)
            send_tick(make_tick(tracker.in_request(), busy_pct, obf_pct));
    endtask

    // Waits until every owed result word has arrived. Each word gives exactly
    // one result, so an empty store means the pipeline is empty.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // Writes all three registers on consecutive cycles while the pipeline is
    // empty. A request may still be half-way through its handshake; the new
    // limits then apply from its next tick, which the predictor mirrors.
    task automatic configure(input logic [15:0] polls, input logic [7:0] attempts,
                             input logic be);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POLL_LIMIT;
        cfg_data  <= polls;
        @(negedge clk);
        cfg_index <= CFG_ATTEMPT_LIMIT;
        cfg_data  <= {8'h00, attempts};
        @(negedge clk);
        cfg_index <= CFG_BIG_ENDIAN;
        cfg_data  <= {15'd0, be};
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.set_limits(polls, attempts, be);
        settings_used++;
    endtask

    // -----------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold-off once a few hundred
    // result words have come through. The sender keeps offering words during
    // the hold-off, so the block fills up and stalls its input.
    // -----------------------------------------------------------------------
    initial
    begin : result_pacing
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && tracker.checked >= 250)
            begin
                held      = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady_run && ($urandom_range(99, 0) < 23);
        end
    end

    // Every result word taken on a rising edge is checked against the oldest
    // owed word.
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.bus_action      = action_t'(bus_action);
            got.bus_byte        = bus_byte;
            got.done_res        = done_res;
            got.success         = success;
            got.read_value      = read_value;
            got.busy_res        = busy_res;
            got.request_dropped = request_dropped;
            tracker.check_action(got);
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus.
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_POLL_LIMIT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        kind      = 1'b0;
        req_write = 1'b0;
        req_word  = 1'b0;
        req_reg   = '0;
        req_value = '0;
        ec_status = '0;
        ec_data   = '0;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, under the reset limits (big-endian words).
        // A byte read of register zero: the request tick is already the first
        // poll, IBF is clear with every bit but IBF and OBF set, then one tick
        // waits on OBF before the data port is read.
        directed_tick(1'b1, 1'b0, 1'b0, 8'h00, 16'h0000, 8'h00, 8'h00);
        directed_tick(1'b0, 1'b0, 1'b0, 8'h00, 16'h0000, 8'hFC, 8'h00);
        directed_tick(1'b0, 1'b0, 1'b0, 8'h00, 16'h0000, 8'h00, 8'h00);
        directed_tick(1'b0, 1'b0, 1'b0, 8'h00, 16'h0000, 8'hFE, 8'h00);
        directed_tick(1'b0, 1'b0, 1'b0, 8'h00, 16'h0000, 8'h01, 8'hFF);
        // A word write to the top register, arriving while IBF is busy, so
        // the second half wraps to register zero. A request during it is
        // dropped.
        directed_tick(1'b1, 1'b1, 1'b1, 8'hFF, 16'hFFFF, 8'h02, 8'h00);
        directed_tick(1'b1, 1'b0, 1'b0, 8'h12, 16'h0000, 8'h00, 8'h00);
        repeat (5)
            directed_tick(1'b0, 1'b0, 1'b0, 8'h00, 16'h0000, 8'h00, 8'h00);
        // A word read at the top register with both waits met on every tick.
        directed_tick(1'b1, 1'b0, 1'b1, 8'hFF, 16'h0000, 8'h01, 8'h00);
        repeat (7)
            directed_tick(1'b0, 1'b0, 1'b0, 8'h00, 16'h0000, 8'h01, 8'($urandom));

        // Random part, one phase per setting. The small limits make timeouts
        // and retries common; the zero limits fail requests at once; the
        // largest limits run long transfers with no idling at all.
        configure(16'd1000, 8'd3, 1'b0);
        run_phase(150, 30, 60);
        configure(16'd2, 8'd2, 1'b1);
        run_phase(150, 45, 45);
        configure(16'd1, 8'd1, 1'b0);
        run_phase(100, 40, 50);
        configure(16'd0, 8'd3, 1'b1);
        run_phase(60, 30, 50);
        configure(16'd4, 8'd0, 1'b0);
        run_phase(60, 30, 50);
        configure(16'hFFFF, 8'hFF, 1'b1);
        steady_run = 1'b1;
        run_phase(150, 30, 50);
        steady_run = 1'b0;
        configure(16'd3, 8'hFF, 1'b0);
        run_phase(150, 55, 40);
        repeat (3)
        begin
            configure(16'($urandom_range(8, 1)), 8'($urandom_range(4, 1)),
                      1'($urandom_range(1, 0)));
            run_phase(90, 40, 50);
        end

        wait_drained();
        $display("Stepped %0d poll ticks under %0d limit settings; %0d result words checked.",
                 tracker.n_ticks, settings_used + 1, tracker.checked);
        $display("Requests: %0d completed, %0d given up after retries, %0d dropped while busy.",
                 tracker.n_ok, tracker.n_failed, tracker.n_dropped);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // This limit is far beyond the length of the whole run.
    initial
    begin : watchdog
        #(12 * 200000);
        $display("Timed out with %0d result words still owed.", tracker.pending());
        $display("Regression FAIL");
        $finish;
    end

endmodule
